// ===== rtl/core/tfd_pkg.sv =====
`default_nettype none

package tfd_pkg;

  // Number of header bytes at the head of each frame; the first two are checked.
  localparam int HEADER_BYTES = 2;

  // Escape value of the length byte: a 16-bit little-endian length follows.
  localparam logic [7:0] LEN_ESCAPE = 8'hff;

  // Configuration register indexes and port widths.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND = 8'd1;

  // Reset values of the magic registers.
  localparam logic [7:0] MAGIC_FIRST_RST  = 8'd71;
  localparam logic [7:0] MAGIC_SECOND_RST = 8'd83;

  // Byte role codes as reported on the result channel.
  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_TYPE    = 3'd1;
  localparam logic [2:0] ROLE_LEN     = 3'd2;
  localparam logic [2:0] ROLE_EXT_LO  = 3'd3;
  localparam logic [2:0] ROLE_EXT_HI  = 3'd4;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd5;

  // Parser phase, one-hot.
  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_TYPE    = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_EXT_LO  = 6'b001000,
    PH_EXT_HI  = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  header_count;
    logic [7:0]  current_type;
    logic [15:0] current_length;
    logic [15:0] bytes_left;
    logic        magic_good;
    logic        seen_element;
  } parse_state_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  element_type;
    logic [15:0] element_length;
    logic        element_start;
    logic [15:0] payload_index;
    logic        frame_done;
    logic        frame_ok;
  } parse_result_t;

  localparam parse_state_t STATE_RST = '{
    phase:          PH_HEADER,
    header_count:   8'd0,
    current_type:   8'd0,
    current_length: 16'd0,
    bytes_left:     16'd0,
    magic_good:     1'b1,
    seen_element:   1'b0
  };

endpackage

`default_nettype wire

// ===== rtl/core/tlv_frame_deframer_unit.sv =====
`default_nettype none

// Type-length-value frame deframer.
// Frame bytes enter on the in_ channel, one item per byte, with in_frame_last
// marking the final byte. Each byte gives exactly one result item on the out_
// channel: its role, the current element type and length, an element-start
// pulse, the payload index, and on the final byte frame_done with frame_ok.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// Each result is registered: a byte accepted at a clock edge is shown at out_
// right after that edge. Throughput is one byte per cycle while the receiver
// does not stall; the parser state update is a single registered step, and
// the result register frees as it is taken.
// When the receiver stalls with a result waiting, in_stall rises and the
// result holds until taken; nothing is lost or repeated.
// The cfg_ port writes the two expected magic bytes (index 0 and 1) and is
// always ready; writes to other indexes are ignored. Write it only while idle.
// Reset (rst_n low, synchronous) empties the result register, returns the
// parser to the start of a frame and loads the magic bytes with 'G' and 'S'.
module tlv_frame_deframer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_data_byte,
  input  wire logic                           in_frame_last,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [2:0]                          out_byte_role,
  output logic [7:0]                          out_element_type,
  output logic [15:0]                         out_element_length,
  output logic                                out_element_start,
  output logic [15:0]                         out_payload_index,
  output logic                                out_frame_done,
  output logic                                out_frame_ok,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]                     cfg_data
);

  tfd_pkg::parse_state_t  st_r;
  tfd_pkg::parse_state_t  st_nxt;
  tfd_pkg::parse_result_t res_r;
  tfd_pkg::parse_result_t res_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [7:0]             magic_first_r;
  logic [7:0]             magic_second_r;
  logic                   in_fire;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= tfd_pkg::MAGIC_FIRST_RST;
      magic_second_r <= tfd_pkg::MAGIC_SECOND_RST;
    end else if (cfg_valid) begin
      if (cfg_index == tfd_pkg::REG_MAGIC_FIRST) begin
        magic_first_r <= cfg_data;
      end
      if (cfg_index == tfd_pkg::REG_MAGIC_SECOND) begin
        magic_second_r <= cfg_data;
      end
    end
  end

  // A new byte is taken unless a result is waiting on a stalled receiver.
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  tfd_step u_step (
    .st           (st_r),
    .data_byte    (in_data_byte),
    .frame_last   (in_frame_last),
    .magic_first  (magic_first_r),
    .magic_second (magic_second_r),
    .st_nxt       (st_nxt),
    .res          (res_nxt)
  );

  // Result register occupancy.
  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Parser state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= tfd_pkg::STATE_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        st_r <= st_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_role      = res_r.byte_role;
  assign out_element_type   = res_r.element_type;
  assign out_element_length = res_r.element_length;
  assign out_element_start  = res_r.element_start;
  assign out_payload_index  = res_r.payload_index;
  assign out_frame_done     = res_r.frame_done;
  assign out_frame_ok       = res_r.frame_ok;

endmodule

`default_nettype wire

// ===== rtl/core/tfd_step.sv =====
`default_nettype none

module tfd_step (
  input  wire tfd_pkg::parse_state_t  st,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   frame_last,
  input  wire logic [7:0]             magic_first,
  input  wire logic [7:0]             magic_second,
  output tfd_pkg::parse_state_t       st_nxt,
  output tfd_pkg::parse_result_t      res
);

  tfd_pkg::parse_state_t ns;
  logic [15:0]           len_known;
  logic                  len_hit;
  logic [15:0]           left_dec;
  logic [7:0]            hdr_inc;

  // Advance the parser by one byte.
  always_comb begin
    ns        = st;
    res       = '0;
    len_known = 16'd0;
    len_hit   = 1'b0;
    left_dec  = st.bytes_left - 16'd1;
    hdr_inc   = st.header_count + 8'd1;

    case (st.phase)
      tfd_pkg::PH_HEADER: begin
        res.byte_role = tfd_pkg::ROLE_HEADER;
        if (st.header_count == 8'd0 && data_byte != magic_first) begin
          ns.magic_good = 1'b0;
        end
        if (st.header_count == 8'd1 && data_byte != magic_second) begin
          ns.magic_good = 1'b0;
        end
        ns.header_count = hdr_inc;
        if (hdr_inc >= 8'(tfd_pkg::HEADER_BYTES)) begin
          ns.phase = tfd_pkg::PH_TYPE;
        end
      end
      tfd_pkg::PH_TYPE: begin
        res.byte_role      = tfd_pkg::ROLE_TYPE;
        res.element_type   = data_byte;
        ns.current_type    = data_byte;
        ns.current_length  = 16'd0;
        ns.phase           = tfd_pkg::PH_LEN;
      end
      tfd_pkg::PH_LEN: begin
        res.byte_role    = tfd_pkg::ROLE_LEN;
        res.element_type = st.current_type;
        if (data_byte == tfd_pkg::LEN_ESCAPE) begin
          ns.phase = tfd_pkg::PH_EXT_LO;
        end else begin
          len_hit   = 1'b1;
          len_known = {8'd0, data_byte};
        end
      end
      tfd_pkg::PH_EXT_LO: begin
        res.byte_role     = tfd_pkg::ROLE_EXT_LO;
        res.element_type  = st.current_type;
        ns.current_length = {8'd0, data_byte};
        ns.phase          = tfd_pkg::PH_EXT_HI;
      end
      tfd_pkg::PH_EXT_HI: begin
        res.byte_role    = tfd_pkg::ROLE_EXT_HI;
        res.element_type = st.current_type;
        len_hit          = 1'b1;
        len_known        = {data_byte, st.current_length[7:0]};
      end
      tfd_pkg::PH_PAYLOAD: begin
        res.byte_role      = tfd_pkg::ROLE_PAYLOAD;
        res.element_type   = st.current_type;
        res.element_length = st.current_length;
        res.payload_index  = st.current_length - st.bytes_left;
        ns.bytes_left      = left_dec;
        if (left_dec == 16'd0) begin
          ns.phase = tfd_pkg::PH_TYPE;
        end
      end
      default: begin
        ns = tfd_pkg::STATE_RST;
      end
    endcase

    // The element length became known on this byte.
    if (len_hit) begin
      ns.current_length  = len_known;
      ns.bytes_left      = len_known;
      ns.seen_element    = 1'b1;
      ns.phase           = (len_known != 16'd0) ? tfd_pkg::PH_PAYLOAD : tfd_pkg::PH_TYPE;
      res.element_length = len_known;
      res.element_start  = 1'b1;
    end

    // The last byte closes the frame and returns the parser to its reset state.
    res.frame_done = frame_last;
    if (frame_last) begin
      res.frame_ok = ns.magic_good && ns.seen_element && (ns.phase == tfd_pkg::PH_TYPE);
      ns           = tfd_pkg::STATE_RST;
    end
  end

  assign st_nxt = ns;

endmodule

`default_nettype wire
